[rtl/prng_printable_rotate_cipher_defines.svh]
// Assertion macros shared by the cipher RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef PRNG_PRINTABLE_ROTATE_CIPHER_DEFINES_SVH
`define PRNG_PRINTABLE_ROTATE_CIPHER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PRPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define PRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/prpc_pkg.sv]
// Shared constants, the queue entry type and the arithmetic helpers
// of the printable rotate cipher. No dependencies.
`default_nettype none
package prpc_pkg;

  localparam int unsigned SEED_W     = 17;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_W      = 7;
  localparam int unsigned MULT_W     = 7;
  localparam int unsigned PROD_W     = SEED_W + MULT_W;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [MULT_W-1:0] LEHMER_MULT = 7'd75;
  localparam logic [SEED_W-1:0] PRIME_MOD   = 17'd65537;
  localparam logic [SEED_W-1:0] SEED_RESET  = 17'd1;
  localparam logic [BYTE_W-1:0] PRINT_LOW   = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HIGH  = 8'd128;
  localparam logic [BYTE_W-1:0] PRINT_SPAN  = 8'd96;

  localparam logic [CFG_ADDR_W-1:0] REG_SEED = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [SEED_W-1:0] key;
  } prpc_item_t;

  function automatic logic [SEED_W-1:0] lehmer_step(input logic [SEED_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [SEED_W-1:0] res;
    prod = {{MULT_W{1'b0}}, x} * {{SEED_W{1'b0}}, LEHMER_MULT};
    lo   = prod[HALF_W-1:0];
    hi   = {{(2*HALF_W-PROD_W){1'b0}}, prod[PROD_W-1:HALF_W]};
    if (lo >= hi) begin
      res = {1'b0, lo - hi};
    end else begin
      res = {1'b0, lo} + PRIME_MOD - {1'b0, hi};
    end
    return res;
  endfunction

  // key mod 96: key = 32*q + r, so the result is 32*(q mod 3) + r
  function automatic logic [KEY_W-1:0] key_mod96(input logic [SEED_W-1:0] key);
    logic [11:0] q;
    logic [4:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    logic [1:0]  q3;
    q  = key[SEED_W-1:5];
    s1 = '0;
    for (int i = 0; i < 6; i++) begin
      s1 = s1 + {3'b000, q[2*i +: 2]};
    end
    s2 = {1'b0, s1[1:0]} + s1[4:2];
    s3 = {2'b00, s2[2]} + {1'b0, s2[1:0]};
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    q3 = s3[1:0];
    return {q3, key[4:0]};
  endfunction

  function automatic logic [BYTE_W-1:0] rotate_byte(input logic [BYTE_W-1:0] b,
                                                    input logic [KEY_W-1:0]  k,
                                                    input logic              dec);
    logic [BYTE_W-1:0] pos;
    logic [BYTE_W-1:0] s;
    if (b < PRINT_LOW || b >= PRINT_HIGH) begin
      return b;
    end
    pos = b - PRINT_LOW;
    if (dec) begin
      s = pos + PRINT_SPAN - {1'b0, k};
    end else begin
      s = pos + {1'b0, k};
    end
    if (s >= PRINT_SPAN) begin
      s = s - PRINT_SPAN;
    end
    return s + PRINT_LOW;
  endfunction

endpackage
`default_nettype wire

[rtl/prpc_front.sv]
// Front end: accepts requests, steps the Lehmer generator and pushes
// byte and keystream value to the queue. Depends on prpc_pkg.
`default_nettype none
module prpc_front
  import prpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_tdata,  // data_byte
  input  wire logic [0:0]        in_tuser,  // restart
  input  wire logic [SEED_W-1:0] seed,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output prpc_item_t             push_item
);

  logic [SEED_W-1:0] gen_r;
  logic [SEED_W-1:0] gen_nxt;
  logic              accept;

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;
  assign accept     = in_tvalid && push_ready;

  assign gen_nxt        = lehmer_step(in_tuser[0] ? seed : gen_r);
  assign push_item.data = in_tdata;
  assign push_item.key  = gen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= SEED_RESET;
    end else if (accept) begin
      gen_r <= gen_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/prpc_fifo.sv]
// Short queue between front end and back end.
// Depends on prpc_pkg and the assertion macros header.
`default_nettype none
`include "prng_printable_rotate_cipher_defines.svh"
module prpc_fifo
  import prpc_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire prpc_item_t push_item,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output prpc_item_t      pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  prpc_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `PRPC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count over depth")
  `PRPC_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count not raised")
  `PRPC_ASSERT_NEXT(a_cnt_dec, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "queue count not lowered")

endmodule
`default_nettype wire

[rtl/prpc_back.sv]
// Back end: reduces the keystream value mod 96, rotates printable bytes
// and holds the result in the output register. Depends on prpc_pkg.
`default_nettype none
module prpc_back
  import prpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              mode,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire prpc_item_t        pop_item,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [BYTE_W-1:0]      out_tdata   // out_byte
);

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic [BYTE_W-1:0] out_data_nxt;

  assign pop_ready    = !out_valid_r || out_tready;
  assign out_data_nxt = rotate_byte(pop_item.data, key_mod96(pop_item.key), mode);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/prng_printable_rotate_cipher.sv]
// Channel   Dir  Handshake            Payload
// in_       in   in_tvalid/in_tready  tdata[7:0] data_byte, tuser[0] restart
// out_      out  out_tvalid/out_tready tdata[7:0] out_byte
// cfg_      in   cfg_we               cfg_addr register index, cfg_wdata value
//
// One byte per cycle sustained while out_tready stays high; out_tvalid rises once the
// accepted byte has passed the queue entry and then the output register.
// The generator step (17x7 multiply and fold) sits in the front end, combinational
// within the gen_r loop; the mod 96 and rotation sit in the back end.
// Synchronous active-low reset; generator and seed reset to one, mode to encrypt.
// A stalled output fills the queue of DEPTH entries, then drops in_tready.
`default_nettype none
module prng_printable_rotate_cipher
  import prpc_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // data_byte
  input  wire logic [0:0]            in_tuser,   // restart
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [BYTE_W-1:0]          out_tdata,  // out_byte
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [SEED_W-1:0]     cfg_wdata
);

  logic [SEED_W-1:0] seed_r;
  logic              mode_r;
  logic              push_valid;
  logic              push_ready;
  prpc_item_t        push_item;
  logic              pop_valid;
  logic              pop_ready;
  prpc_item_t        pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SEED: seed_r <= cfg_wdata;
        REG_MODE: mode_r <= cfg_wdata[0];
        default:  ;
      endcase
    end
  end

  prpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .seed       (seed_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  prpc_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  prpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
